// File: hw/rtl/archive_byte_stream_decryptor_top_macros.svh
// ----------------------------------------------------------------------------
// archive byte stream decryptor assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ARCHIVE_BYTE_STREAM_DECRYPTOR_TOP_MACROS_SVH
`define ARCHIVE_BYTE_STREAM_DECRYPTOR_TOP_MACROS_SVH

// same-cycle implication
`define ABSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ABSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/absd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absd_pkg
// shared types, codes and small arithmetic helpers of the byte stream decryptor
// ----------------------------------------------------------------------------
package absd_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned SnW    = 7;
  localparam int unsigned PosW   = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [PosW-1:0] PosAStart = 4'd0;
  localparam logic [PosW-1:0] PosBStart = 4'd8;

  typedef enum logic [FuncW-1:0] {
    FUNC_DECRYPT = 2'd0,
    FUNC_RESTART = 2'd1,
    FUNC_SKIP    = 2'd2
  } func_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_A_LOW   = 3'd0,
    CFG_KEY_A_HIGH  = 3'd1,
    CFG_KEY_B_LOW   = 3'd2,
    CFG_KEY_B_HIGH  = 3'd3,
    CFG_START_SN    = 3'd4,
    CFG_DECRYPT_EN  = 3'd5
  } cfg_reg_t;

  // n mod 7 for a 7-bit n: quotient estimate never high by more than zero,
  // low by at most one, so one conditional subtract finishes it
  function automatic logic [2:0] mod7(input logic [SnW-1:0] n);
    logic [13:0]    prod;
    logic [4:0]     q;
    logic [SnW-1:0] r;
    prod = 14'(n) * 14'd73;
    q    = prod[13:9];
    r    = n - 7'(q) * 7'd7;
    if (r >= 7'd7) begin
      r = r - 7'd7;
    end
    return r[2:0];
  endfunction

  // n mod 12 for a 7-bit n, same scheme
  function automatic logic [3:0] mod12(input logic [SnW-1:0] n);
    logic [11:0]    prod;
    logic [3:0]     q;
    logic [SnW-1:0] r;
    prod = 12'(n) * 12'd21;
    q    = prod[11:8];
    r    = n - 7'(q) * 7'd12;
    if (r >= 7'd12) begin
      r = r - 7'd12;
    end
    return r[3:0];
  endfunction

  // byte idx of a 16-byte table held as two 64-bit words
  function automatic logic [ByteW-1:0] table_byte(input logic [KeyW-1:0] lo,
                                                  input logic [KeyW-1:0] hi,
                                                  input logic [PosW-1:0] idx);
    logic [KeyW-1:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: ByteW];
  endfunction

endpackage

// File: hw/rtl/absd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absd stream interfaces
// valid/ready channels for cipher input and plain output transactions
// ----------------------------------------------------------------------------
interface absd_in_if;
  logic                            valid;
  logic                            ready;
  logic [absd_pkg::FuncW-1:0]      func;
  logic [absd_pkg::ByteW-1:0]      cipher_byte;

  modport source (output valid, output func, output cipher_byte, input ready);
  modport sink   (input valid, input func, input cipher_byte, output ready);
endinterface

interface absd_out_if;
  logic                            valid;
  logic                            ready;
  logic [absd_pkg::ByteW-1:0]      plain_byte;

  modport source (output valid, output plain_byte, input ready);
  modport sink   (input valid, input plain_byte, output ready);
endinterface

// File: hw/rtl/archive_byte_stream_decryptor_top.sv
`timescale 1ns / 1ps
// the result of each input transaction is registered in the output register
// throughput: 1 transaction per cycle while the output is not stalled; keystream update and
// output byte are computed in one pass from the keystream registers
// reset: synchronous active-low rst_n clears keys, config and keystream
// (pos_a 0, pos_b 8, swap 0, string number 0) and empties the output register
// ----------------------------------------------------------------------------
// archive_byte_stream_decryptor_top
// byte stream decryptor with two 16-byte key tables and a stepping keystream
// ----------------------------------------------------------------------------
module archive_byte_stream_decryptor_top (
  input  logic                              clk,
  input  logic                              rst_n,
  absd_in_if.sink                           in_ch,
  absd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [absd_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [absd_pkg::KeyW-1:0]         cfg_wdata
);

  logic [absd_pkg::KeyW-1:0]  key_a_low_r, key_a_high_r, key_b_low_r, key_b_high_r;
  logic [absd_pkg::SnW-1:0]   start_sn_r;
  logic                       decrypt_en_r;

  logic [absd_pkg::PosW-1:0]  pos_a_r, pos_a_nxt;
  logic [absd_pkg::PosW-1:0]  pos_b_r, pos_b_nxt;
  logic [absd_pkg::SnW-1:0]   sn_r, sn_nxt;
  logic                       swap_r, swap_nxt;

  logic                       out_valid_r;
  logic [absd_pkg::ByteW-1:0] out_byte_r, out_byte_nxt;

  // keystream step results
  logic [absd_pkg::PosW-1:0]  step_pos_a, step_pos_b;
  logic [absd_pkg::SnW-1:0]   step_sn;
  logic                       step_swap;
  logic [4:0]                 inc_a, inc_b;
  logic [absd_pkg::SnW-1:0]   sn_adv;

  logic [absd_pkg::ByteW-1:0] mix_byte, sw_byte, dec_byte;
  logic                       accept;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.plain_byte = out_byte_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_low_r  <= '0;
      key_a_high_r <= '0;
      key_b_low_r  <= '0;
      key_b_high_r <= '0;
      start_sn_r   <= '0;
      decrypt_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (absd_pkg::cfg_reg_t'(cfg_index))
        absd_pkg::CFG_KEY_A_LOW:  key_a_low_r  <= cfg_wdata;
        absd_pkg::CFG_KEY_A_HIGH: key_a_high_r <= cfg_wdata;
        absd_pkg::CFG_KEY_B_LOW:  key_b_low_r  <= cfg_wdata;
        absd_pkg::CFG_KEY_B_HIGH: key_b_high_r <= cfg_wdata;
        absd_pkg::CFG_START_SN:   start_sn_r   <= cfg_wdata[absd_pkg::SnW-1:0];
        absd_pkg::CFG_DECRYPT_EN: decrypt_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // output byte from the current keystream
  always_comb begin
    mix_byte = absd_pkg::table_byte(key_b_low_r, key_b_high_r, pos_b_r)
             ^ {1'b0, sn_r} ^ in_ch.cipher_byte;
    sw_byte  = swap_r ? {mix_byte[3:0], mix_byte[7:4]} : mix_byte;
    dec_byte = sw_byte ^ absd_pkg::table_byte(key_a_low_r, key_a_high_r, pos_a_r);
  end

  // one keystream step
  always_comb begin
    inc_a      = {1'b0, pos_a_r} + 5'd1;
    inc_b      = {1'b0, pos_b_r} + 5'd1;
    sn_adv     = sn_r + 7'd2;
    step_pos_a = inc_a[3:0];
    step_pos_b = inc_b[3:0];
    step_sn    = sn_r;
    step_swap  = swap_r;
    if (!inc_a[4]) begin
      if (inc_b > 5'd12) begin
        step_pos_b = '0;
        step_swap  = !swap_r;
      end
    end else if (inc_b <= 5'd8) begin
      step_pos_a = '0;
      step_swap  = !swap_r;
    end else begin
      // end of round
      step_sn = sn_adv;
      if (swap_r) begin
        step_pos_a = {1'b0, absd_pkg::mod7(sn_adv)};
        step_pos_b = absd_pkg::mod12(sn_adv) + 4'd2;
        step_swap  = 1'b0;
      end else begin
        step_pos_b = {1'b0, absd_pkg::mod7(sn_adv)};
        step_pos_a = absd_pkg::mod12(sn_adv) + 4'd3;
        step_swap  = 1'b1;
      end
    end
  end

  // transaction decode
  always_comb begin
    pos_a_nxt    = pos_a_r;
    pos_b_nxt    = pos_b_r;
    sn_nxt       = sn_r;
    swap_nxt     = swap_r;
    out_byte_nxt = '0;
    unique case (in_ch.func)
      absd_pkg::FUNC_DECRYPT: begin
        if (decrypt_en_r) begin
          out_byte_nxt = dec_byte;
          pos_a_nxt    = step_pos_a;
          pos_b_nxt    = step_pos_b;
          sn_nxt       = step_sn;
          swap_nxt     = step_swap;
        end else begin
          out_byte_nxt = in_ch.cipher_byte;
        end
      end
      absd_pkg::FUNC_RESTART: begin
        pos_a_nxt = absd_pkg::PosAStart;
        pos_b_nxt = absd_pkg::PosBStart;
        sn_nxt    = start_sn_r;
        swap_nxt  = 1'b0;
      end
      absd_pkg::FUNC_SKIP: begin
        if (decrypt_en_r) begin
          pos_a_nxt = step_pos_a;
          pos_b_nxt = step_pos_b;
          sn_nxt    = step_sn;
          swap_nxt  = step_swap;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_a_r     <= absd_pkg::PosAStart;
      pos_b_r     <= absd_pkg::PosBStart;
      sn_r        <= '0;
      swap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pos_a_r     <= pos_a_nxt;
        pos_b_r     <= pos_b_nxt;
        sn_r        <= sn_nxt;
        swap_r      <= swap_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r <= out_byte_nxt;
    end
  end

endmodule

// File: hw/rtl/absd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absd_checker
// port-level checks of the decryptor, bound to the top level
// ----------------------------------------------------------------------------
`include "archive_byte_stream_decryptor_top_macros.svh"

module absd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [absd_pkg::FuncW-1:0]       in_func,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [absd_pkg::ByteW-1:0]       out_plain_byte
);

  // a stalled result holds
  `ABSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_plain_byte))
  // every input transaction yields a result next cycle
  `ABSD_ASSERT_NEXT(a_in_to_out, in_valid && in_ready, out_valid)
  // only decrypt transactions carry a nonzero byte
  `ABSD_ASSERT_NEXT(a_zero_result, in_valid && in_ready && (in_func != absd_pkg::FUNC_DECRYPT), out_plain_byte == '0)
  // an empty output register never blocks the input
  `ABSD_ASSERT_SAME(a_ready_empty, !out_valid, in_ready)

endmodule

bind archive_byte_stream_decryptor_top absd_checker u_absd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_func        (in_ch.func),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_plain_byte (out_ch.plain_byte)
);
